// File: hw/rtl/exptok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package exptok_pkg;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LOW_L   = 8'h6C;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_LOW_T   = 8'h74;

  // Length of the keyword "let"
  localparam int unsigned KEYWORD_LEN = 3;

  // Token queue between scanner and output stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_ID   = 2'd2
  } scan_mode_t;

  typedef enum logic [2:0] {
    TT_INT    = 3'd0,
    TT_DOUBLE = 3'd1,
    TT_IDENT  = 3'd2,
    TT_LET    = 3'd3,
    TT_OP     = 3'd4,
    TT_DELIM  = 3'd5,
    TT_EOF    = 3'd6
  } token_type_t;

  typedef struct packed {
    token_type_t ttype;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  symbol;
    logic        last;
  } token_t;

  // One scanner decision: one or two tokens
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  // Character of "let" at a given index
  function automatic logic [7:0] let_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_LOW_L;
      2'd1:    ch = CH_LOW_E;
      2'd2:    ch = CH_LOW_T;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/exptok_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Character input channel
interface exptok_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

// Token output channel
interface exptok_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_type;
  logic [15:0] start_position;
  logic [15:0] token_length;
  logic [7:0]  symbol;
  logic        last_of_run;

  modport source (output valid, output token_type, output start_position,
                  output token_length, output symbol, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_type, input start_position,
                  input token_length, input symbol, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/exptok_front.sv
`timescale 1ns / 1ps
`default_nettype none

module exptok_front #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [7:0]            in_char,
  output logic                  push,
  output exptok_pkg::entry_t    push_data,
  input  logic                  q_full
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] KwLen  = POSITION_BITS'(exptok_pkg::KEYWORD_LEN);

  exptok_pkg::scan_mode_t     mode_r, mode_nxt;
  logic                       dot_r, dot_nxt;
  logic                       kw_r, kw_nxt;
  logic [POSITION_BITS-1:0]   pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]   start_r, start_nxt;
  logic [POSITION_BITS-1:0]   len_r, len_nxt;

  logic                       fire;
  logic                       is_dig, is_alp, is_op, is_delim, is_dot;
  logic                       pend, cont, single;
  logic [POSITION_BITS-1:0]   pos_inc, len_inc;
  exptok_pkg::token_t         flush_tok, single_tok, eof_tok;
  exptok_pkg::entry_t         ent;
  logic                       has_tok;

  function automatic logic [15:0] clamp16(input logic [POSITION_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // Classify the character
  always_comb begin
    is_dig   = (in_char inside {[8'h30:8'h39]});
    is_alp   = (in_char inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    is_dot   = (in_char == exptok_pkg::CH_DOT);
    is_op    = (in_char inside {exptok_pkg::CH_PERCENT, exptok_pkg::CH_PLUS,
                                exptok_pkg::CH_MINUS, exptok_pkg::CH_SLASH,
                                exptok_pkg::CH_STAR, exptok_pkg::CH_EQUAL});
    is_delim = (in_char inside {exptok_pkg::CH_SEMI, exptok_pkg::CH_LPAREN,
                                exptok_pkg::CH_RPAREN});
  end

  assign pos_inc = (pos_r == PosMax) ? pos_r : pos_r + 1'b1;
  assign len_inc = (len_r == PosMax) ? len_r : len_r + 1'b1;
  assign pend    = (mode_r != exptok_pkg::MODE_IDLE);
  assign cont    = ((mode_r == exptok_pkg::MODE_NUM) && (is_dig || is_dot)) ||
                   ((mode_r == exptok_pkg::MODE_ID) && (is_dig || is_alp));
  assign single  = is_op || is_delim;

  // Build candidate tokens
  always_comb begin
    flush_tok        = '0;
    flush_tok.start  = clamp16(start_r);
    flush_tok.length = clamp16(len_r);
    if (mode_r == exptok_pkg::MODE_NUM) begin
      flush_tok.ttype = dot_r ? exptok_pkg::TT_DOUBLE : exptok_pkg::TT_INT;
    end else begin
      flush_tok.ttype = (kw_r && (len_r == KwLen)) ? exptok_pkg::TT_LET
                                                    : exptok_pkg::TT_IDENT;
    end

    single_tok        = '0;
    single_tok.ttype  = is_op ? exptok_pkg::TT_OP : exptok_pkg::TT_DELIM;
    single_tok.start  = clamp16(pos_r);
    single_tok.length = 16'd1;
    single_tok.symbol = in_char;

    eof_tok       = '0;
    eof_tok.ttype = exptok_pkg::TT_EOF;
    eof_tok.start = clamp16(pos_r);
  end

  // Next scanner state and the entry for the queue
  always_comb begin
    mode_nxt  = mode_r;
    dot_nxt   = dot_r;
    kw_nxt    = kw_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    ent       = '0;
    has_tok   = 1'b0;

    if (in_kind == exptok_pkg::KIND_END) begin
      // flush, emit end of file, restart
      has_tok   = 1'b1;
      ent.two   = pend;
      ent.tok0  = pend ? flush_tok : eof_tok;
      ent.tok1  = eof_tok;
      mode_nxt  = exptok_pkg::MODE_IDLE;
      dot_nxt   = 1'b0;
      kw_nxt    = 1'b0;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
    end else if (cont) begin
      // extend the pending token
      if (mode_r == exptok_pkg::MODE_NUM) begin
        if (is_dot) begin
          dot_nxt = 1'b1;
        end
      end else if (len_r < KwLen) begin
        kw_nxt = kw_r && (in_char == exptok_pkg::let_char(len_r[1:0]));
      end else begin
        kw_nxt = 1'b0;
      end
      len_nxt = len_inc;
      pos_nxt = pos_inc;
    end else begin
      // close any pending token, then start fresh
      has_tok  = pend || single;
      ent.two  = pend && single;
      ent.tok0 = pend ? flush_tok : single_tok;
      ent.tok1 = single_tok;
      mode_nxt = exptok_pkg::MODE_IDLE;
      if (is_dig) begin
        mode_nxt  = exptok_pkg::MODE_NUM;
        dot_nxt   = 1'b0;
        start_nxt = pos_r;
        len_nxt   = POSITION_BITS'(1);
      end else if (is_alp) begin
        mode_nxt  = exptok_pkg::MODE_ID;
        kw_nxt    = (in_char == exptok_pkg::CH_LOW_L);
        start_nxt = pos_r;
        len_nxt   = POSITION_BITS'(1);
      end
      pos_nxt = pos_inc;
    end

    ent.tok0.last = !ent.two;
    ent.tok1.last = 1'b1;
  end

  assign push      = fire && has_tok;
  assign push_data = ent;

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= exptok_pkg::MODE_IDLE;
      dot_r   <= 1'b0;
      kw_r    <= 1'b0;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      dot_r   <= dot_nxt;
      kw_r    <= kw_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

  // A pending token always has at least one character
  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != exptok_pkg::MODE_IDLE) |-> (len_r != '0))
    else $error("pending token with zero length");

  // End of text leaves the scanner idle at position zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_kind == exptok_pkg::KIND_END)) |=>
      ((mode_r == exptok_pkg::MODE_IDLE) && (pos_r == '0)))
    else $error("scanner not cleared after end of text");

  // A pending token never starts past the current position
  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != exptok_pkg::MODE_IDLE) |-> (start_r <= pos_r))
    else $error("token start beyond text position");

endmodule

`default_nettype wire

// File: hw/rtl/exptok_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module exptok_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  exptok_pkg::entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output exptok_pkg::entry_t  head,
  output logic                empty
);

  localparam int unsigned Depth = exptok_pkg::QDEPTH;
  localparam int unsigned PtrW  = exptok_pkg::QPTR_W;
  localparam int unsigned CntW  = exptok_pkg::QCNT_W;

  exptok_pkg::entry_t   slot_r [Depth];
  logic [PtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]      count_r, count_nxt;

  assign full  = (count_r == CntW'(Depth));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full token queue");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty token queue");

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CntW'(Depth))
    else $error("token queue count overflow");

endmodule

`default_nettype wire

// File: hw/rtl/exptok_back.sv
`timescale 1ns / 1ps
`default_nettype none

module exptok_back (
  input  logic                clk,
  input  logic                rst_n,
  input  exptok_pkg::entry_t  head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output exptok_pkg::token_t  out_tok
);

  exptok_pkg::token_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                second_r, second_nxt;
  logic                load_ok;

  assign load_ok = !out_valid_r || out_ready;

  // Hand out the first token, then the second of a pair
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    second_nxt    = second_r;
    pop           = 1'b0;
    if (load_ok) begin
      if (second_r) begin
        out_nxt       = head.tok1;
        out_valid_nxt = 1'b1;
        second_nxt    = 1'b0;
        pop           = 1'b1;
      end else if (!q_empty) begin
        out_nxt       = head.tok0;
        out_valid_nxt = 1'b1;
        second_nxt    = head.two;
        pop           = !head.two;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_r;

  // The second half of a pair is still in the queue head
  assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (!q_empty && head.two))
    else $error("second token pending without a paired entry");

  // While a pair is split, the token on the output is not the last one
  assert property (@(posedge clk) disable iff (!rst_n)
    (second_r && out_valid_r) |-> !out_r.last)
    else $error("first of a pair marked last");

  // Only the final token of a run may be end of file
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.ttype == exptok_pkg::TT_EOF)) |-> out_r.last)
    else $error("end of file not marked last");

endmodule

`default_nettype wire

// File: hw/rtl/expression_tokenizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Modport  Payload
// in_ch     in   sink     kind, char_code
// out_ch    out  source   token_type, start_position, token_length, symbol, last_of_run
//
// One character is taken per cycle; the scanner decides in the cycle of the transfer.
// Tokens leave one per cycle from a registered output while out_ch.ready is high.
// A four-entry token queue decouples scanner and output; in_ch.ready drops only
// when it is full. Reset is synchronous on rst_n and needs no clearing pass.
// A transferred character's token passes the queue, then the output register.

module expression_tokenizer_unit #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  exptok_in_if.sink    in_ch,
  exptok_out_if.source out_ch
);

  logic                push, pop, q_full, q_empty;
  exptok_pkg::entry_t  push_data, head;
  exptok_pkg::token_t  out_tok;

  exptok_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .in_char   (in_ch.char_code),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  exptok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  exptok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_tok   (out_tok)
  );

  // Drive the result payload
  assign out_ch.token_type     = 3'(out_tok.ttype);
  assign out_ch.start_position = out_tok.start;
  assign out_ch.token_length   = out_tok.length;
  assign out_ch.symbol         = out_tok.symbol;
  assign out_ch.last_of_run    = out_tok.last;

endmodule

`default_nettype wire
